// ----- hw/rtl/ssfb_pkg.sv -----
// Shared types, command codes and the glyph table for the seven-segment frame builder.
// No dependencies; imported by ssfb_digit_split and the core.
`timescale 1ns / 1ps

package ssfb_pkg;

    // Bus commands
    localparam logic [7:0] CMD_DATA_MODE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS   = 8'hC0;
    localparam logic [7:0] CMD_CONTROL   = 8'h80;
    localparam logic [7:0] CTRL_ON_BIT   = 8'h08;
    localparam logic [7:0] SEG_POINT     = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ON = 2'd1;

    localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;

    // Digits on the display and the cap on sent digits
    localparam int NUM_DIGITS      = 4;
    localparam int DIGIT_COUNT_MAX = 4;
    localparam int DIGIT_LIMIT_INT =
        (DIGIT_COUNT_MAX > NUM_DIGITS) ? NUM_DIGITS : DIGIT_COUNT_MAX;
    localparam logic [2:0] DIGIT_LIMIT = 3'(DIGIT_LIMIT_INT);

    // Reciprocals: n/1000 = (n*67109)>>26 for n < 2^16,
    // r/100 = (r*41)>>12 for r < 1000, r/10 = (r*205)>>11 for r < 128
    localparam logic [16:0] RECIP_1000 = 17'd67109;
    localparam int          SHIFT_1000 = 26;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam int          SHIFT_100  = 12;
    localparam logic [7:0]  RECIP_10   = 8'd205;
    localparam int          SHIFT_10   = 11;

    // Item entering the digit splitter
    typedef struct packed {
        logic [15:0] number;
        logic [3:0]  dots;    // dots[3] belongs to the leftmost digit
        logic        lz;
        logic [2:0]  count;   // already capped
        logic [1:0]  pos;
    } ssfb_in_t;

    // Decimal digits, most significant first
    typedef struct packed {
        logic [6:0]  q_th;    // thousands quotient, up to 65
        logic [3:0]  q_h;
        logic [3:0]  q_t;
        logic [3:0]  q_o;
        logic [3:0]  dots;
        logic        lz;
        logic [2:0]  count;
        logic [1:0]  pos;
    } ssfb_split_t;

    function automatic logic [7:0] ssfb_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'h0: g = 8'h3F;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5B;
            4'h3: g = 8'h4F;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6D;
            4'h6: g = 8'h7D;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7F;
            4'h9: g = 8'h6F;
            4'hA: g = 8'h77;
            4'hB: g = 8'h7C;
            4'hC: g = 8'h39;
            4'hD: g = 8'h5E;
            4'hE: g = 8'h79;
            4'hF: g = 8'h71;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ----- hw/rtl/ssfb_digit_split.sv -----
// Three-stage pipeline that splits a 16-bit number into four decimal digits.
// Depends on ssfb_pkg (item types and reciprocal constants).
`timescale 1ns / 1ps

module ssfb_digit_split (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssfb_pkg::ssfb_in_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssfb_pkg::ssfb_split_t out_item
);
    import ssfb_pkg::*;

    // stage 1: thousands quotient
    logic        v1_reg;
    ssfb_in_t    it1_reg;
    logic [6:0]  qth1_reg;
    // stage 2: hundreds quotient and remainder below 1000
    logic        v2_reg;
    ssfb_in_t    it2_reg;
    logic [6:0]  qth2_reg;
    logic [9:0]  r2_reg;
    logic [3:0]  qh2_reg;
    // stage 3: tens and ones
    logic        v3_reg;
    ssfb_split_t it3_reg;

    logic        rdy1, rdy2, rdy3;
    logic [32:0] prod_th;
    logic [15:0] sub_th;
    logic [9:0]  r1_next;
    logic [15:0] prod_h;
    logic [9:0]  sub_h;
    logic [6:0]  rem_h;
    logic [14:0] prod_t;
    logic [3:0]  qt_next;
    logic [6:0]  sub_t;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign prod_th = 33'(in_item.number) * 33'(RECIP_1000);

    assign sub_th  = 16'(qth1_reg) * 16'd1000;
    assign r1_next = 10'(it1_reg.number - sub_th);
    assign prod_h  = 16'(r1_next) * 16'(RECIP_100);

    assign sub_h   = 10'(qh2_reg) * 10'd100;
    assign rem_h   = 7'(r2_reg - sub_h);
    assign prod_t  = 15'(rem_h) * 15'(RECIP_10);
    assign qt_next = prod_t[SHIFT_10 +: 4];
    assign sub_t   = 7'(qt_next) * 7'd10;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            it1_reg  <= in_item;
            qth1_reg <= prod_th[SHIFT_1000 +: 7];
        end
        if (rdy2 && v1_reg) begin
            it2_reg  <= it1_reg;
            qth2_reg <= qth1_reg;
            r2_reg   <= r1_next;
            qh2_reg  <= prod_h[SHIFT_100 +: 4];
        end
        if (rdy3 && v2_reg) begin
            it3_reg.q_th  <= qth2_reg;
            it3_reg.q_h   <= qh2_reg;
            it3_reg.q_t   <= qt_next;
            it3_reg.q_o   <= 4'(rem_h - sub_t);
            it3_reg.dots  <= it2_reg.dots;
            it3_reg.lz    <= it2_reg.lz;
            it3_reg.count <= it2_reg.count;
            it3_reg.pos   <= it2_reg.pos;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = it3_reg;

endmodule

// ----- hw/rtl/seven_segment_number_frame_builder_core.sv -----
// Top level of the seven-segment frame builder: stream ports, config registers,
// glyph stage and byte sequencer. Depends on ssfb_pkg and ssfb_digit_split.
`timescale 1ns / 1ps

// Each accepted number turns into one command frame on the m_ stream: 0x40
// (start and stop), 0xC0 plus start_position (start; stop too when no digits
// are sent), the rightmost digit_count segment bytes (stop after the final
// one), then 0x80 plus brightness and the on bit (start, stop, tlast).
// digit_count above four is sent as four. A number yields digit_count + 3
// bytes. The byte sequencer emits one byte per cycle while m_tready is
// high, and that sets the sustained rate. Input passes the three digit
// split stages, the glyph stage and the sequencer register before the
// first byte goes out. Up to five numbers are held in flight
// while the output is stalled. Config writes (cfg_index 0 brightness,
// 1 display on) are always taken and apply to frames whose control byte
// has not yet been sent; write them only while the block is idle.
module seven_segment_number_frame_builder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] number, [23:20] dot_mask, [19:16] unused, [26:24] digit_count,
    // [28:27] start_position, [31:29] zero
    input  logic [31:0] s_tdata,
    // [0] show_leading_zeros
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] bus_byte
    output logic [7:0]  m_tdata,
    // [0] start_before, [1] stop_after
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import ssfb_pkg::*;

    // ---------------- configuration ----------------
    logic [2:0] bright_reg;
    logic       disp_on_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg  <= BRIGHTNESS_RESET;
            disp_on_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BRIGHTNESS: bright_reg  <= cfg_data[2:0];
                REG_DISPLAY_ON: disp_on_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpack and digit split ----------------
    ssfb_in_t    in_item;
    ssfb_split_t sp_item;
    logic        sp_valid;
    logic        sp_ready;
    logic [2:0]  raw_count;

    assign raw_count      = s_tdata[26:24];
    assign in_item.number = s_tdata[15:0];
    assign in_item.dots   = s_tdata[23:20];
    assign in_item.lz     = s_tuser[0];
    assign in_item.count  = (raw_count > DIGIT_LIMIT) ? DIGIT_LIMIT : raw_count;
    assign in_item.pos    = s_tdata[28:27];

    ssfb_digit_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (sp_valid),
        .out_ready (sp_ready),
        .out_item  (sp_item)
    );

    // ---------------- glyph stage ----------------
    // Leading zeros blank unless lz is set; the ones digit always shows.
    logic       gv_reg;
    logic [7:0] gseg_reg [NUM_DIGITS];
    logic [2:0] gcount_reg;
    logic [1:0] gpos_reg;
    logic       g_ready;
    logic       nz_th, nz_h, nz_t;
    logic [7:0] seg_next [NUM_DIGITS];

    assign nz_th = (sp_item.q_th != 7'd0);
    assign nz_h  = (sp_item.q_h  != 4'd0);
    assign nz_t  = (sp_item.q_t  != 4'd0);

    always_comb begin
        seg_next[0] = nz_th ? ssfb_glyph(sp_item.q_th[3:0])
                    : (sp_item.lz ? ssfb_glyph(4'd0) : 8'h00);
        seg_next[1] = nz_h ? ssfb_glyph(sp_item.q_h)
                    : ((sp_item.lz || nz_th) ? ssfb_glyph(4'd0) : 8'h00);
        seg_next[2] = nz_t ? ssfb_glyph(sp_item.q_t)
                    : ((sp_item.lz || nz_th || nz_h) ? ssfb_glyph(4'd0) : 8'h00);
        seg_next[3] = ssfb_glyph(sp_item.q_o);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (sp_item.dots[NUM_DIGITS - 1 - k])
                seg_next[k] = seg_next[k] | SEG_POINT;
        end
    end

    // ---------------- byte sequencer ----------------
    logic       fv_reg;
    logic [7:0] fseg_reg [NUM_DIGITS];
    logic [2:0] fcount_reg;
    logic [1:0] fpos_reg;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       f_load;
    logic       f_final;
    logic [1:0] seg_idx;

    assign f_final  = (step_reg == fcount_reg + 3'd2);
    assign f_load   = !fv_reg || (m_tready && f_final);
    assign g_ready  = !gv_reg || f_load;
    assign sp_ready = g_ready;
    assign seg_idx  = step_reg[1:0] + 2'd2 - fcount_reg[1:0];

    always_comb begin
        step_next = step_reg;
        if (f_load)
            step_next = 3'd0;
        else if (m_tready)
            step_next = step_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gv_reg   <= 1'b0;
            fv_reg   <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            if (g_ready) gv_reg <= sp_valid;
            if (f_load)  fv_reg <= gv_reg;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (g_ready && sp_valid) begin
            gseg_reg   <= seg_next;
            gcount_reg <= sp_item.count;
            gpos_reg   <= sp_item.pos;
        end
        if (f_load && gv_reg) begin
            fseg_reg   <= gseg_reg;
            fcount_reg <= gcount_reg;
            fpos_reg   <= gpos_reg;
        end
    end

    // Byte selection from the held frame
    always_comb begin
        m_tdata = fseg_reg[seg_idx];
        m_tuser = 2'b00;
        m_tlast = 1'b0;
        if (step_reg == 3'd0) begin
            m_tdata = CMD_DATA_MODE;
            m_tuser = 2'b11;
        end else if (step_reg == 3'd1) begin
            m_tdata = CMD_ADDRESS | {6'd0, fpos_reg};
            m_tuser = {(fcount_reg == 3'd0), 1'b1};
        end else if (f_final) begin
            m_tdata = CMD_CONTROL | {5'd0, bright_reg}
                    | (disp_on_reg ? CTRL_ON_BIT : 8'h00);
            m_tuser = 2'b11;
            m_tlast = 1'b1;
        end else begin
            m_tuser = {(step_reg == fcount_reg + 3'd1), 1'b0};
        end
    end

    assign m_tvalid = fv_reg;

endmodule
